FILE: rtl/core/pgw_pkg.sv
// Shared types and codes of the planar graphics write unit.
package pgw_pkg;

  // Bus access kinds as they arrive on the mode field.
  localparam logic [1:0] MODE_REG_WRITE = 2'd0;
  localparam logic [1:0] MODE_MEM_READ  = 2'd1;
  localparam logic [1:0] MODE_MEM_WRITE = 2'd2;

  // Register indices in the low byte of a register word.
  localparam logic [7:0] GC_IDX_SR_COLOR   = 8'h00;
  localparam logic [7:0] GC_IDX_SR_ENABLE  = 8'h01;
  localparam logic [7:0] GC_IDX_ROTATE     = 8'h03;
  localparam logic [7:0] GC_IDX_READ_PLANE = 8'h04;
  localparam logic [7:0] GC_IDX_WRITE_MODE = 8'h05;
  localparam logic [7:0] GC_IDX_BIT_MASK   = 8'h08;
  localparam logic [7:0] SEQ_IDX_MAP_MASK  = 8'h02;

  // Write mode codes that the write path carries out.
  localparam logic [1:0] WM_DATA  = 2'd0;
  localparam logic [1:0] WM_LATCH = 2'd1;

  // Entries of the command queue between front and back.
  localparam int unsigned QUEUE_DEPTH = 2;

  typedef enum logic [1:0] {
    OP_NONE  = 2'd0,
    OP_REG   = 2'd1,
    OP_READ  = 2'd2,
    OP_WRITE = 2'd3
  } op_e;

  typedef enum logic [2:0] {
    REG_NONE       = 3'd0,
    REG_SR_COLOR   = 3'd1,
    REG_SR_ENABLE  = 3'd2,
    REG_ROTATE     = 3'd3,
    REG_READ_PLANE = 3'd4,
    REG_WRITE_MODE = 3'd5,
    REG_BIT_MASK   = 3'd6,
    REG_MAP_MASK   = 3'd7
  } reg_e;

  typedef enum logic [1:0] {
    LF_REPLACE = 2'd0,
    LF_AND     = 2'd1,
    LF_OR      = 2'd2,
    LF_XOR     = 2'd3
  } lf_e;

  typedef struct packed {
    op_e         op;
    reg_e        target;
    logic [7:0]  value;
    logic [15:0] addr;
  } cmd_t;

  function automatic logic [7:0] rotate_right8(input logic [7:0] v, input logic [2:0] n);
    logic [15:0] t;
    t = {v, v} >> n;
    return t[7:0];
  endfunction

endpackage

FILE: rtl/core/pgw_front.sv
// Front end: classify bus accesses into queue commands.
module pgw_front (
  input  logic            in_valid_i,
  output logic            in_ready_o,
  input  logic [1:0]      mode_i,
  input  logic            port_select_i,
  input  logic [15:0]     byte_address_i,
  input  logic [15:0]     bus_data_i,
  output logic            push_o,
  output pgw_pkg::cmd_t   cmd_o,
  input  logic            full_i
);
  import pgw_pkg::*;

  logic [7:0] idx;
  reg_e       target;

  assign idx = bus_data_i[7:0];

  always_comb begin
    target = REG_NONE;
    if (port_select_i) begin
      if (idx == SEQ_IDX_MAP_MASK) target = REG_MAP_MASK;
    end else begin
      unique case (idx)
        GC_IDX_SR_COLOR:   target = REG_SR_COLOR;
        GC_IDX_SR_ENABLE:  target = REG_SR_ENABLE;
        GC_IDX_ROTATE:     target = REG_ROTATE;
        GC_IDX_READ_PLANE: target = REG_READ_PLANE;
        GC_IDX_WRITE_MODE: target = REG_WRITE_MODE;
        GC_IDX_BIT_MASK:   target = REG_BIT_MASK;
        default:           target = REG_NONE;
      endcase
    end
  end

  always_comb begin
    cmd_o.addr   = byte_address_i;
    cmd_o.target = REG_NONE;
    cmd_o.value  = bus_data_i[7:0];
    unique case (mode_i)
      MODE_REG_WRITE: begin
        cmd_o.op     = OP_REG;
        cmd_o.target = target;
        cmd_o.value  = bus_data_i[15:8];
      end
      MODE_MEM_READ:  cmd_o.op = OP_READ;
      MODE_MEM_WRITE: cmd_o.op = OP_WRITE;
      default:        cmd_o.op = OP_NONE;
    endcase
  end

  assign in_ready_o = !full_i;
  assign push_o     = in_valid_i && !full_i;

endmodule

FILE: rtl/core/pgw_queue.sv
// Short command queue that decouples front and back.
module pgw_queue (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  pgw_pkg::cmd_t push_cmd_i,
  output logic          full_o,
  input  logic          pop_i,
  output logic          empty_o,
  output pgw_pkg::cmd_t head_o
);
  import pgw_pkg::*;

  localparam int unsigned PtrBits = $clog2(QUEUE_DEPTH);

  cmd_t               entry_q [QUEUE_DEPTH];
  logic [PtrBits-1:0] wr_ptr_q, rd_ptr_q;
  logic [PtrBits:0]   count_q;

  assign full_o  = count_q == (PtrBits + 1)'(QUEUE_DEPTH);
  assign empty_o = count_q == '0;
  assign head_o  = entry_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push_i) entry_q[wr_ptr_q] <= push_cmd_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) wr_ptr_q <= wr_ptr_q + 1'b1;
      if (pop_i)  rd_ptr_q <= rd_ptr_q + 1'b1;
      if (push_i && !pop_i)      count_q <= count_q + 1'b1;
      else if (pop_i && !push_i) count_q <= count_q - 1'b1;
    end
  end

endmodule

FILE: rtl/core/pgw_back.sv
// Back end: register file, plane store, latches and write path.
module pgw_back #(
  parameter int unsigned ADDRESS_BITS = 16
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          empty_i,
  input  pgw_pkg::cmd_t cmd_i,
  output logic          pop_o,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  output logic [7:0]    read_data_o
);
  import pgw_pkg::*;

  localparam int unsigned Words = 1 << ADDRESS_BITS;

  typedef enum logic [2:0] {
    ST_CLEAR = 3'b001,
    ST_IDLE  = 3'b010,
    ST_MEM   = 3'b100
  } state_e;

  state_e state_q, state_d;

  logic [3:0] sr_color_q, sr_color_d;
  logic [3:0] sr_en_q, sr_en_d;
  lf_e        lf_q, lf_d;
  logic [2:0] rot_q, rot_d;
  logic [1:0] rplane_q, rplane_d;
  logic [1:0] wmode_q, wmode_d;
  logic [7:0] bmask_q, bmask_d;
  logic [3:0] pen_q, pen_d;
  logic [31:0] latch_q, latch_d;

  cmd_t       cur_q, cur_d;
  logic       out_valid_q, out_valid_d;
  logic [7:0] out_data_q, out_data_d;

  logic [ADDRESS_BITS-1:0] clr_cnt_q, clr_cnt_d;

  logic [31:0]             plane_mem [Words];
  logic [31:0]             mem_rdata_q;
  logic                    mem_re, mem_we;
  logic [ADDRESS_BITS-1:0] mem_raddr, mem_waddr;
  logic [31:0]             mem_wdata;

  logic        slot_free;
  logic [31:0] new_word;
  logic        write_ok;

  always_ff @(posedge clk_i) begin
    if (mem_we) plane_mem[mem_waddr] <= mem_wdata;
    if (mem_re) mem_rdata_q <= plane_mem[mem_raddr];
  end

  // Write path: mode 0 data/set-reset/logic/mask, mode 1 latch copy.
  always_comb begin
    logic [7:0] rot, src, res, lat, old;
    rot      = rotate_right8(cur_q.value, rot_q);
    new_word = mem_rdata_q;
    for (int p = 0; p < 4; p++) begin
      lat = latch_q[8*p +: 8];
      old = mem_rdata_q[8*p +: 8];
      src = sr_en_q[p] ? {8{sr_color_q[p]}} : rot;
      unique case (lf_q)
        LF_AND:  res = src & lat;
        LF_OR:   res = src | lat;
        LF_XOR:  res = src ^ lat;
        default: res = src;
      endcase
      if (wmode_q == WM_LATCH) begin
        new_word[8*p +: 8] = pen_q[p] ? lat : old;
      end else begin
        new_word[8*p +: 8] = pen_q[p] ? ((res & bmask_q) | (lat & ~bmask_q)) : old;
      end
    end
  end

  assign write_ok  = (wmode_q == WM_DATA) || (wmode_q == WM_LATCH);
  assign slot_free = !out_valid_q || out_ready_i;

  always_comb begin
    state_d     = state_q;
    sr_color_d  = sr_color_q;
    sr_en_d     = sr_en_q;
    lf_d        = lf_q;
    rot_d       = rot_q;
    rplane_d    = rplane_q;
    wmode_d     = wmode_q;
    bmask_d     = bmask_q;
    pen_d       = pen_q;
    latch_d     = latch_q;
    cur_d       = cur_q;
    clr_cnt_d   = clr_cnt_q;
    out_valid_d = out_valid_q && !out_ready_i;
    out_data_d  = out_data_q;
    pop_o       = 1'b0;
    mem_re      = 1'b0;
    mem_raddr   = cmd_i.addr[ADDRESS_BITS-1:0];
    mem_we      = 1'b0;
    mem_waddr   = cur_q.addr[ADDRESS_BITS-1:0];
    mem_wdata   = new_word;

    unique case (state_q)
      ST_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = clr_cnt_q;
        mem_wdata = '0;
        clr_cnt_d = clr_cnt_q + 1'b1;
        if (&clr_cnt_q) state_d = ST_IDLE;
      end
      ST_IDLE: begin
        if (!empty_i && slot_free) begin
          pop_o = 1'b1;
          cur_d = cmd_i;
          if (cmd_i.op == OP_READ || cmd_i.op == OP_WRITE) begin
            mem_re  = 1'b1;
            state_d = ST_MEM;
          end else begin
            out_valid_d = 1'b1;
            out_data_d  = '0;
            if (cmd_i.op == OP_REG) begin
              unique case (cmd_i.target)
                REG_SR_COLOR:   sr_color_d = cmd_i.value[3:0];
                REG_SR_ENABLE:  sr_en_d    = cmd_i.value[3:0];
                REG_ROTATE: begin
                  rot_d = cmd_i.value[2:0];
                  lf_d  = lf_e'(cmd_i.value[4:3]);
                end
                REG_READ_PLANE: rplane_d   = cmd_i.value[1:0];
                REG_WRITE_MODE: wmode_d    = cmd_i.value[1:0];
                REG_BIT_MASK:   bmask_d    = cmd_i.value;
                REG_MAP_MASK:   pen_d      = cmd_i.value[3:0];
                default: ;
              endcase
            end
          end
        end
      end
      ST_MEM: begin
        out_valid_d = 1'b1;
        state_d     = ST_IDLE;
        if (cur_q.op == OP_READ) begin
          latch_d    = mem_rdata_q;
          out_data_d = mem_rdata_q[{rplane_q, 3'b000} +: 8];
        end else begin
          out_data_d = '0;
          mem_we     = write_ok;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i) begin
    cur_q      <= cur_d;
    out_data_q <= out_data_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      clr_cnt_q   <= '0;
      sr_color_q  <= '0;
      sr_en_q     <= '0;
      lf_q        <= LF_REPLACE;
      rot_q       <= '0;
      rplane_q    <= '0;
      wmode_q     <= WM_DATA;
      bmask_q     <= '1;
      pen_q       <= '1;
      latch_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      clr_cnt_q   <= clr_cnt_d;
      sr_color_q  <= sr_color_d;
      sr_en_q     <= sr_en_d;
      lf_q        <= lf_d;
      rot_q       <= rot_d;
      rplane_q    <= rplane_d;
      wmode_q     <= wmode_d;
      bmask_q     <= bmask_d;
      pen_q       <= pen_d;
      latch_q     <= latch_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign read_data_o = out_data_q;

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_CLEAR |-> !pop_o)
    else $error("command popped during clearing pass");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_MEM |-> !out_valid_q)
    else $error("memory access finishing while result slot is occupied");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_o && (cmd_i.op == OP_READ || cmd_i.op == OP_WRITE) |=> state_q == ST_MEM)
    else $error("memory command did not enter access state");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && !$past(out_valid_q) && out_data_q != '0 |-> $past(cur_q.op == OP_READ))
    else $error("nonzero result from a command other than a read");

endmodule

FILE: rtl/core/planar_graphics_write_unit.sv
// Top level of the planar graphics write unit.
// Four-plane display memory with a graphics-controller write path. Every bus
// transaction on the input channel returns exactly one transaction on the
// output channel: the byte of the selected read plane for a memory read, zero
// for a register write, a memory write or the unused mode code. Register
// writes carry the index in bus_data_i[7:0] and the value in bus_data_i[15:8];
// port_select_i picks the graphics controller (0) or the sequencer map mask
// (1). A front end classifies each transaction and pushes it into a two-entry
// command queue, so the input side keeps accepting, until the queue fills,
// while the back end or the output side stalls. The back end takes register
// writes and unused codes in its idle state; memory reads and writes go on to
// an access state, set by the registered read port of the plane store (read
// issued when idle, latch load or modify-and-write in the access state). After
// reset the back end zeroes all 2**ADDRESS_BITS store words, one word a cycle,
// before it runs the first command; the front end fills the queue meanwhile.
// Memory writes in modes 2 and 3 are dropped; only memory reads load latches.
module planar_graphics_write_unit #(
  parameter int unsigned ADDRESS_BITS = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [1:0]  mode_i,
  input  logic        port_select_i,
  input  logic [15:0] byte_address_i,
  input  logic [15:0] bus_data_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [7:0]  read_data_o
);
  import pgw_pkg::*;

  // Front to queue
  logic push;
  cmd_t push_cmd;
  logic full;

  // Queue to back
  logic pop;
  logic empty;
  cmd_t head;

  // Classify the incoming transaction; hold off when the queue is full.
  pgw_front u_front (
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .mode_i         (mode_i),
    .port_select_i  (port_select_i),
    .byte_address_i (byte_address_i),
    .bus_data_i     (bus_data_i),
    .push_o         (push),
    .cmd_o          (push_cmd),
    .full_i         (full)
  );

  // Buffer commands so that front and back stall independently.
  pgw_queue u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .push_cmd_i (push_cmd),
    .full_o     (full),
    .pop_i      (pop),
    .empty_o    (empty),
    .head_o     (head)
  );

  // Execute commands in order and drive the result register.
  pgw_back #(
    .ADDRESS_BITS (ADDRESS_BITS)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .empty_i     (empty),
    .cmd_i       (head),
    .pop_o       (pop),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .read_data_o (read_data_o)
  );

endmodule

FILE: test/planar_graphics_write_unit_test.sv
// Self-checking testbench of the planar graphics write unit.
module planar_graphics_write_unit_test;
  import pgw_pkg::*;

  // The fourth mode code does nothing but still returns a zero byte.
  localparam logic [1:0] MODE_UNUSED  = 2'd3;
  // A graphics controller index that no register answers to.
  localparam logic [7:0] GC_IDX_SPARE = 8'h06;

  localparam int unsigned PLANE_WORDS   = 65536;
  localparam int unsigned ITEMS_PER_RUN = 350;    // random accesses per idling phase
  localparam int unsigned HOLDOFF_LEN   = 80;     // receiver hold-off in cycles
  localparam int unsigned QUIET_LIMIT   = 250000; // covers the store clearing pass
  localparam int unsigned TAIL_CYCLES   = 40;

  // One bus transaction plus the pacing that goes with it.
  typedef struct {
    logic [1:0]  mode;
    logic        port;
    logic [15:0] addr;
    logic [15:0] data;
    int unsigned tx_gap;     // percent of free slots the sender leaves empty
    int unsigned rx_stall;   // percent of cycles the receiver stalls
    bit          drain_first;
    bit          rx_holdoff;
  } bus_access_t;

  logic        clk_i          = 1'b0;
  logic        rst_ni         = 1'b0;
  logic        in_valid_i     = 1'b0;
  logic        in_ready_o;
  logic [1:0]  mode_i         = '0;
  logic        port_select_i  = 1'b0;
  logic [15:0] byte_address_i = '0;
  logic [15:0] bus_data_i     = '0;
  logic        out_valid_o;
  logic        out_ready_i    = 1'b0;
  logic [7:0]  read_data_o;

  planar_graphics_write_unit dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .mode_i         (mode_i),
    .port_select_i  (port_select_i),
    .byte_address_i (byte_address_i),
    .bus_data_i     (bus_data_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .read_data_o    (read_data_o)
  );

  initial begin
    forever #1 clk_i = ~clk_i;
  end

  // ---------------------------------------------------------------------------
  // Shadow copy of the graphics controller, the latches and the plane store.
  // ---------------------------------------------------------------------------
  logic [3:0]  sr_color;
  logic [3:0]  sr_enable;
  lf_e         logic_fn;
  logic [2:0]  rot_count;
  logic [1:0]  read_sel;
  logic [1:0]  wr_mode;
  logic [7:0]  bit_mask;
  logic [3:0]  map_mask;
  logic [31:0] latches;
  logic [31:0] planes [PLANE_WORDS];

  bus_access_t bus_accesses[$];   // transactions still to be offered
  logic [7:0]  read_bytes_due[$]; // bytes the output channel owes, oldest first

  bus_access_t cur_access;
  logic [7:0]  model_byte;
  int unsigned rx_stall_pct = 0;
  logic        hold_toggle  = 1'b0;
  logic        hold_seen    = 1'b0;
  int unsigned hold_left    = 0;
  int unsigned quiet_cycles = 0;
  int unsigned mismatch_count = 0;

  // Pacing applied to the next transaction pushed by the stimulus tasks.
  int unsigned gen_tx;
  int unsigned gen_rx;
  bit          gen_drain;
  bit          gen_hold;
  logic [15:0] addr_pool [8];

  function automatic logic [7:0] ror8(input logic [7:0] v, input logic [2:0] n);
    return (v >> n) | (v << (4'd8 - n));
  endfunction

  // Advance the shadow state by one bus transaction; return the byte it reads.
  task automatic run_bus_access(input bus_access_t a, output logic [7:0] rd);
    logic [7:0]  idx;
    logic [7:0]  val;
    logic [7:0]  rot;
    logic [7:0]  latch;
    logic [7:0]  src;
    logic [7:0]  res;
    logic [7:0]  merged;
    logic [31:0] old_word;
    logic [31:0] new_word;
    int          p;
    rd  = '0;
    idx = a.data[7:0];
    val = a.data[15:8];
    case (a.mode)
      MODE_REG_WRITE: begin
        if (a.port) begin
          if (idx == SEQ_IDX_MAP_MASK) map_mask = val[3:0];
        end else begin
          case (idx)
            GC_IDX_SR_COLOR:   sr_color = val[3:0];
            GC_IDX_SR_ENABLE:  sr_enable = val[3:0];
            GC_IDX_ROTATE: begin
              rot_count = val[2:0];
              logic_fn  = lf_e'(val[4:3]);
            end
            GC_IDX_READ_PLANE: read_sel = val[1:0];
            GC_IDX_WRITE_MODE: wr_mode = val[1:0];
            GC_IDX_BIT_MASK:   bit_mask = val;
            default: ;
          endcase
        end
      end
      MODE_MEM_READ: begin
        latches = planes[a.addr];
        rd      = latches[8*read_sel +: 8];
      end
      MODE_MEM_WRITE: begin
        old_word = planes[a.addr];
        new_word = old_word;
        rot      = ror8(a.data[7:0], rot_count);
        for (p = 0; p < 4; p++) begin
          latch = latches[8*p +: 8];
          src   = sr_enable[p] ? {8{sr_color[p]}} : rot;
          case (logic_fn)
            LF_AND:  res = src & latch;
            LF_OR:   res = src | latch;
            LF_XOR:  res = src ^ latch;
            default: res = src;
          endcase
          merged = (res & bit_mask) | (latch & ~bit_mask);
          if (wr_mode == WM_LATCH)
            new_word[8*p +: 8] = map_mask[p] ? latch : old_word[8*p +: 8];
          else
            new_word[8*p +: 8] = map_mask[p] ? merged : old_word[8*p +: 8];
        end
        // Modes two and three leave the store untouched.
        if (wr_mode == WM_DATA || wr_mode == WM_LATCH) planes[a.addr] = new_word;
      end
      default: ;
    endcase
  endtask

  // ---------------------------------------------------------------------------
  // Stimulus helpers: queue one transaction with the current pacing.
  // ---------------------------------------------------------------------------
  task automatic push_access(input logic [1:0] mode, input logic port,
                             input logic [15:0] addr, input logic [15:0] data);
    bus_access_t a;
    a.mode        = mode;
    a.port        = port;
    a.addr        = addr;
    a.data        = data;
    a.tx_gap      = gen_tx;
    a.rx_stall    = gen_rx;
    a.drain_first = gen_drain;
    a.rx_holdoff  = gen_hold;
    bus_accesses.push_back(a);
    gen_drain = 1'b0;
    gen_hold  = 1'b0;
  endtask

  task automatic push_reg(input logic port, input logic [7:0] idx, input logic [7:0] val);
    push_access(MODE_REG_WRITE, port, 16'($urandom_range(0, 65535)), {val, idx});
  endtask

  // Pick a write mode value, mostly the data path, with random upper bits.
  function automatic logic [7:0] pick_write_mode();
    int unsigned r;
    r = $urandom_range(0, 19);
    if (r < 12) return {6'($urandom_range(0, 63)), WM_DATA};
    if (r < 17) return {6'($urandom_range(0, 63)), WM_LATCH};
    return {6'($urandom_range(0, 63)), 2'($urandom_range(2, 3))};
  endfunction

  // One random register write: mostly known registers, some that nobody owns.
  task automatic push_random_reg();
    case ($urandom_range(0, 10))
      0: push_reg(1'b0, GC_IDX_SR_COLOR, 8'($urandom_range(0, 255)));
      1: push_reg(1'b0, GC_IDX_SR_ENABLE, 8'($urandom_range(0, 255)));
      2, 3: push_reg(1'b0, GC_IDX_ROTATE, 8'($urandom_range(0, 255)));
      4: push_reg(1'b0, GC_IDX_READ_PLANE, 8'($urandom_range(0, 255)));
      5: push_reg(1'b0, GC_IDX_WRITE_MODE, pick_write_mode());
      6: push_reg(1'b0, GC_IDX_BIT_MASK, 8'($urandom_range(0, 255)));
      7: push_reg(1'b1, SEQ_IDX_MAP_MASK, 8'($urandom_range(0, 255)));
      8: push_reg(1'b0, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
      9: push_reg(1'b1, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
      default: push_reg(1'b0, GC_IDX_BIT_MASK, 8'hff);
    endcase
  endtask

  // ---------------------------------------------------------------------------
  // Driver: offer queued transactions, hold each until it is accepted, and
  // update the shadow state at the edge that accepts it.
  // ---------------------------------------------------------------------------
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i     <= 1'b0;
      mode_i         <= '0;
      port_select_i  <= 1'b0;
      byte_address_i <= '0;
      bus_data_i     <= '0;
    end else begin
      if (in_valid_i && in_ready_o) begin
        run_bus_access(cur_access, model_byte);
        read_bytes_due.push_back(model_byte);
      end
      // Only a free slot may take the next transaction; a held one stays put.
      if (!in_valid_i || in_ready_o) begin
        if (bus_accesses.size() != 0
            && !(bus_accesses[0].drain_first && read_bytes_due.size() != 0)
            && $urandom_range(0, 99) >= bus_accesses[0].tx_gap) begin
          cur_access = bus_accesses.pop_front();
          in_valid_i     <= 1'b1;
          mode_i         <= cur_access.mode;
          port_select_i  <= cur_access.port;
          byte_address_i <= cur_access.addr;
          bus_data_i     <= cur_access.data;
          rx_stall_pct   <= cur_access.rx_stall;
          if (cur_access.rx_holdoff) hold_toggle <= ~hold_toggle;
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor: check every output transaction against the oldest owed byte and
  // pace the ready line, including the long hold-off the driver asks for.
  // ---------------------------------------------------------------------------
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
      hold_left   <= 0;
    end else begin
      if (out_valid_o && out_ready_i) begin
        if (read_bytes_due.size() == 0) begin
          $error("read_data %02h arrived with no transaction outstanding", read_data_o);
          mismatch_count++;
        end else if (read_data_o !== read_bytes_due[0]) begin
          $error("read_data mismatch: expected %02h, actual %02h",
                 read_bytes_due[0], read_data_o);
          mismatch_count++;
          void'(read_bytes_due.pop_front());
        end else begin
          void'(read_bytes_due.pop_front());
        end
      end
      if (hold_toggle != hold_seen) begin
        hold_seen   <= hold_toggle;
        hold_left   <= HOLDOFF_LEN;
        out_ready_i <= 1'b0;
      end else if (hold_left != 0) begin
        hold_left   <= hold_left - 1;
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= ($urandom_range(0, 99) >= rx_stall_pct);
      end
    end
  end

  // Watchdog: end the run when neither channel moves for too long.
  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus, reset and end of run.
  // ---------------------------------------------------------------------------
  initial begin
    int unsigned tx_gaps [4];
    int unsigned rx_stalls [4];
    int unsigned target;
    int unsigned ph;
    logic [15:0] a;
    logic [15:0] b;

    tx_gaps   = '{0, 56, 0, 36};
    rx_stalls = '{0, 0, 56, 36};

    // Mirror the reset state of the block, store cleared.
    sr_color  = '0;
    sr_enable = '0;
    logic_fn  = LF_REPLACE;
    rot_count = '0;
    read_sel  = '0;
    wr_mode   = WM_DATA;
    bit_mask  = 8'hff;
    map_mask  = 4'hf;
    latches   = '0;
    foreach (planes[i]) planes[i] = '0;

    addr_pool[0] = 16'h0000;
    addr_pool[1] = 16'hffff;
    for (int i = 2; i < 8; i++) addr_pool[i] = 16'($urandom_range(0, 65535));

    // Directed part, no idling.
    gen_tx    = 0;
    gen_rx    = 0;
    gen_drain = 1'b0;
    gen_hold  = 1'b0;
    push_access(MODE_MEM_READ, 1'b0, 16'h0000, 16'h0000);   // cleared store
    push_access(MODE_MEM_READ, 1'b1, 16'hffff, 16'hffff);
    push_reg(1'b0, GC_IDX_SR_COLOR, 8'hfa);
    push_reg(1'b0, GC_IDX_SR_ENABLE, 8'hf3);
    push_reg(1'b0, GC_IDX_ROTATE, {3'b111, LF_XOR, 3'd3});
    push_access(MODE_MEM_WRITE, 1'b0, 16'hffff, 16'hffa5);  // high byte ignored
    push_access(MODE_MEM_READ, 1'b0, 16'hffff, 16'h0000);
    push_reg(1'b0, GC_IDX_READ_PLANE, 8'hff);
    push_access(MODE_MEM_READ, 1'b0, 16'hffff, 16'h0000);
    push_reg(1'b0, GC_IDX_BIT_MASK, 8'h3c);
    push_reg(1'b1, SEQ_IDX_MAP_MASK, 8'hf6);
    push_access(MODE_MEM_WRITE, 1'b1, 16'h1234, 16'h005a);
    push_access(MODE_MEM_READ, 1'b0, 16'h1234, 16'h0000);
    // Latch copy with the read mode bit set, which must be ignored.
    push_reg(1'b0, GC_IDX_WRITE_MODE, 8'h08 | WM_LATCH);
    push_access(MODE_MEM_WRITE, 1'b0, 16'h0000, 16'h00ff);
    push_access(MODE_MEM_READ, 1'b0, 16'h0000, 16'h0000);
    // Write modes two and three drop the write.
    push_reg(1'b0, GC_IDX_WRITE_MODE, 8'h02);
    push_access(MODE_MEM_WRITE, 1'b0, 16'h0000, 16'h0000);
    push_reg(1'b0, GC_IDX_WRITE_MODE, 8'h03);
    push_access(MODE_MEM_WRITE, 1'b0, 16'h0000, 16'h0000);
    push_access(MODE_MEM_READ, 1'b0, 16'h0000, 16'h0000);
    push_access(MODE_UNUSED, 1'b1, 16'h0000, 16'hffff);
    // Writes to registers that nobody owns.
    push_reg(1'b0, GC_IDX_SPARE, 8'hff);
    push_reg(1'b1, GC_IDX_BIT_MASK, 8'h00);
    push_reg(1'b0, SEQ_IDX_MAP_MASK, 8'h00);
    push_access(MODE_MEM_READ, 1'b0, 16'h1234, 16'h0000);

    // Random part, one run per idling phase. Each run starts after the block
    // has drained; two runs open with a long receiver hold-off.
    for (ph = 0; ph < 4; ph++) begin
      gen_tx    = tx_gaps[ph];
      gen_rx    = rx_stalls[ph];
      gen_drain = 1'b1;
      gen_hold  = (ph == 0 || ph == 2);
      target    = bus_accesses.size() + ITEMS_PER_RUN;
      while (bus_accesses.size() < target) begin
        a = addr_pool[3'($urandom_range(0, 7))];
        b = addr_pool[3'($urandom_range(0, 7))];
        case ($urandom_range(0, 19))
          0, 1, 2, 3, 4, 5, 6, 7: begin
            // Read-modify-write: load latches, write, read back.
            push_access(MODE_MEM_READ, 1'($urandom_range(0, 1)), a,
                        16'($urandom_range(0, 65535)));
            push_access(MODE_MEM_WRITE, 1'($urandom_range(0, 1)), a,
                        16'($urandom_range(0, 65535)));
            push_access(MODE_MEM_READ, 1'($urandom_range(0, 1)), a,
                        16'($urandom_range(0, 65535)));
          end
          8, 9: begin
            // Copy through the latches from one word to another.
            push_access(MODE_MEM_READ, 1'b0, a, 16'($urandom_range(0, 65535)));
            push_access(MODE_MEM_WRITE, 1'b0, b, 16'($urandom_range(0, 65535)));
            push_access(MODE_MEM_READ, 1'b0, b, 16'($urandom_range(0, 65535)));
          end
          10, 11, 12, 13, 14: push_random_reg();
          15, 16: push_access(MODE_MEM_WRITE, 1'($urandom_range(0, 1)), a,
                              16'($urandom_range(0, 65535)));
          17: push_access(MODE_MEM_READ, 1'($urandom_range(0, 1)), a,
                          16'($urandom_range(0, 65535)));
          default: push_access(2'($urandom_range(0, 3)), 1'($urandom_range(0, 1)),
                               16'($urandom_range(0, 65535)),
                               16'($urandom_range(0, 65535)));
        endcase
      end
    end

    // Hold reset, then release it on a clock edge.
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (bus_accesses.size() != 0 || in_valid_i) @(posedge clk_i);
    while (read_bytes_due.size() != 0) @(posedge clk_i);
    repeat (TAIL_CYCLES) @(posedge clk_i);

    if (mismatch_count == 0)
      $display("TB_OK");
    else
      $display("TB_ERROR");
    $finish;
  end

endmodule
